@@ rtl/gpioev_pkg.sv @@
// ----------------------------------------------------------------------------
// gpioev_pkg
// Codes, register word offsets, item layout and result layout for the gpio bank
// ----------------------------------------------------------------------------
package gpioev_pkg;

    localparam int unsigned KIND_W      = 2;
    localparam int unsigned WORD_W      = 6;
    localparam int unsigned DATA_W      = 32;
    localparam int unsigned FSEL_W      = 30;
    localparam int unsigned FSEL_WORDS  = 4;
    localparam int unsigned FN_W        = 3;
    localparam int unsigned PINS_PER_FW = 10;
    localparam int unsigned PULL_W      = 2;

    localparam int unsigned IN_TDATA_W  = 72;
    localparam int unsigned OUT_TDATA_W = 168;

    localparam logic [KIND_W-1:0] KIND_READ  = 2'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_TICK  = 2'd2;

    localparam logic [WORD_W-1:0] W_FSEL0   = 6'd0;
    localparam logic [WORD_W-1:0] W_FSEL1   = 6'd1;
    localparam logic [WORD_W-1:0] W_FSEL2   = 6'd2;
    localparam logic [WORD_W-1:0] W_FSEL3   = 6'd3;
    localparam logic [WORD_W-1:0] W_SET     = 6'd7;
    localparam logic [WORD_W-1:0] W_CLR     = 6'd10;
    localparam logic [WORD_W-1:0] W_LEV     = 6'd13;
    localparam logic [WORD_W-1:0] W_EDS     = 6'd16;
    localparam logic [WORD_W-1:0] W_REN     = 6'd19;
    localparam logic [WORD_W-1:0] W_FEN     = 6'd22;
    localparam logic [WORD_W-1:0] W_AREN    = 6'd31;
    localparam logic [WORD_W-1:0] W_AFEN    = 6'd34;
    localparam logic [WORD_W-1:0] W_PUD     = 6'd37;
    localparam logic [WORD_W-1:0] W_PUDCLK  = 6'd38;

    localparam logic [FN_W-1:0] FN_OUTPUT = 3'b001;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [WORD_W-1:0] reg_word;
        logic [DATA_W-1:0] write_data;
        logic [DATA_W-1:0] pin_sample;
    } item_t;

    typedef struct packed {
        logic                 event_irq;
        logic [2*DATA_W-1:0]  pull_mode;
        logic [DATA_W-1:0]    pin_enable;
        logic [DATA_W-1:0]    pin_drive;
        logic [DATA_W-1:0]    read_data;
    } result_t;

endpackage

@@ rtl/gpio_bank_with_edge_events.sv @@
// ----------------------------------------------------------------------------
// gpio_bank_with_edge_events
// 32-pin gpio bank with word registers, edge event capture and pull control
// ----------------------------------------------------------------------------
// usage
//   slave stream carries one item per handshake: a bus read, a bus write or a
//   pin sample tick (tuser holds the kind). the master stream returns one
//   result per item, showing the bank state after that item: read data,
//   output latch, output enables, pull state per pin and the event interrupt.
//   an accepted item waits in the input register; the update logic loads
//   the result register from it when that register is empty or being read.
//   throughput: one item per cycle while m_axis_tready is high, set by the
//   single-pass update between the two registers; all state lives in flops.
//   reset: state registers clear (payload registers are not reset), every pin
//   is an input, no events, pulls off, both stream registers empty.
//   stall: while the receiver holds tready low the result register holds; one
//   more item waits in the input register, then s_axis_tready drops.
// ----------------------------------------------------------------------------
module gpio_bank_with_edge_events #(
    parameter int unsigned PIN_COUNT = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // reg_word, write_data, pin_sample, zero pad
    input  logic [gpioev_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // kind
    input  logic [gpioev_pkg::KIND_W-1:0]      s_axis_tuser,
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // read_data, pin_drive, pin_enable, pull_mode, event_irq, zero pad
    output logic [gpioev_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import gpioev_pkg::*;

    localparam logic [DATA_W-1:0] PIN_MASK =
        DATA_W'((64'd1 << PIN_COUNT) - 64'd1);
    localparam int unsigned RES_W = $bits(result_t);

    logic                in_valid_reg;
    item_t               in_item_reg;
    logic                out_valid_reg;
    result_t             out_res_reg;
    logic                advance;

    logic [FSEL_W-1:0]   fsel_reg [FSEL_WORDS];
    logic [FSEL_W-1:0]   fsel_next [FSEL_WORDS];
    logic [DATA_W-1:0]   latch_reg, latch_next;
    logic [DATA_W-1:0]   eds_reg, eds_next;
    logic [DATA_W-1:0]   ren_reg, ren_next;
    logic [DATA_W-1:0]   fen_reg, fen_next;
    logic [DATA_W-1:0]   aren_reg, aren_next;
    logic [DATA_W-1:0]   afen_reg, afen_next;
    logic [PULL_W-1:0]   pud_reg, pud_next;
    logic [2*DATA_W-1:0] pull_reg, pull_next;
    logic [DATA_W-1:0]   lev_reg, lev_next;

    logic [DATA_W-1:0]   rd;
    logic [DATA_W-1:0]   wd;
    logic [DATA_W-1:0]   smp;
    logic [DATA_W-1:0]   rise;
    logic [DATA_W-1:0]   fall;
    logic [DATA_W-1:0]   oe;
    logic                tick_fire;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign tick_fire     = advance && (in_item_reg.kind == KIND_TICK);

    assign wd   = in_item_reg.write_data & PIN_MASK;
    assign smp  = in_item_reg.pin_sample & PIN_MASK;
    assign rise = smp & ~lev_reg & (ren_reg | aren_reg);
    assign fall = ~smp & lev_reg & (fen_reg | afen_reg);

    // register read mux
    always_comb
    begin
        rd = '0;
        if (in_item_reg.kind == KIND_READ)
        begin
            unique case (in_item_reg.reg_word)
                W_FSEL0:  rd = DATA_W'(fsel_reg[0]);
                W_FSEL1:  rd = DATA_W'(fsel_reg[1]);
                W_FSEL2:  rd = DATA_W'(fsel_reg[2]);
                W_FSEL3:  rd = DATA_W'(fsel_reg[3]);
                W_LEV:    rd = lev_reg;
                W_EDS:    rd = eds_reg;
                W_REN:    rd = ren_reg;
                W_FEN:    rd = fen_reg;
                W_AREN:   rd = aren_reg;
                W_AFEN:   rd = afen_reg;
                W_PUD:    rd = DATA_W'(pud_reg);
                default:  rd = '0;
            endcase
        end
    end

    // state update for writes and ticks
    always_comb
    begin
        for (int i = 0; i < FSEL_WORDS; i++)
        begin
            fsel_next[i] = fsel_reg[i];
        end
        latch_next = latch_reg;
        eds_next   = eds_reg;
        ren_next   = ren_reg;
        fen_next   = fen_reg;
        aren_next  = aren_reg;
        afen_next  = afen_reg;
        pud_next   = pud_reg;
        pull_next  = pull_reg;
        lev_next   = lev_reg;
        unique case (in_item_reg.kind)
            KIND_WRITE:
            begin
                unique case (in_item_reg.reg_word)
                    W_FSEL0:  fsel_next[0] = in_item_reg.write_data[FSEL_W-1:0];
                    W_FSEL1:  fsel_next[1] = in_item_reg.write_data[FSEL_W-1:0];
                    W_FSEL2:  fsel_next[2] = in_item_reg.write_data[FSEL_W-1:0];
                    W_FSEL3:  fsel_next[3] = in_item_reg.write_data[FSEL_W-1:0];
                    W_SET:    latch_next = latch_reg | wd;
                    W_CLR:    latch_next = latch_reg & ~in_item_reg.write_data;
                    W_EDS:    eds_next = eds_reg & ~in_item_reg.write_data;
                    W_REN:    ren_next = wd;
                    W_FEN:    fen_next = wd;
                    W_AREN:   aren_next = wd;
                    W_AFEN:   afen_next = wd;
                    W_PUD:    pud_next = in_item_reg.write_data[PULL_W-1:0];
                    W_PUDCLK:
                    begin
                        for (int p = 0; p < DATA_W; p++)
                        begin
                            if (wd[p])
                            begin
                                pull_next[PULL_W*p +: PULL_W] = pud_reg;
                            end
                        end
                    end
                    default:  ;
                endcase
            end
            KIND_TICK:
            begin
                eds_next = eds_reg | ((rise | fall) & PIN_MASK);
                lev_next = smp;
            end
            default:  ;
        endcase
    end

    // output enables from the updated function select
    for (genvar p = 0; p < DATA_W; p++)
    begin : g_oe
        localparam int unsigned FW  = (p / PINS_PER_FW) % FSEL_WORDS;
        localparam int unsigned LSB = (p % PINS_PER_FW) * FN_W;
        assign oe[p] = PIN_MASK[p] && (fsel_next[FW][LSB +: FN_W] == FN_OUTPUT);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < FSEL_WORDS; i++)
            begin
                fsel_reg[i] <= '0;
            end
            latch_reg <= '0;
            eds_reg   <= '0;
            ren_reg   <= '0;
            fen_reg   <= '0;
            aren_reg  <= '0;
            afen_reg  <= '0;
            pud_reg   <= '0;
            pull_reg  <= '0;
            lev_reg   <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                for (int i = 0; i < FSEL_WORDS; i++)
                begin
                    fsel_reg[i] <= fsel_next[i];
                end
                latch_reg <= latch_next;
                eds_reg   <= eds_next;
                ren_reg   <= ren_next;
                fen_reg   <= fen_next;
                aren_reg  <= aren_next;
                afen_reg  <= afen_next;
                pud_reg   <= pud_next;
                pull_reg  <= pull_next;
                lev_reg   <= lev_next;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_item_reg.kind       <= s_axis_tuser;
            in_item_reg.reg_word   <= s_axis_tdata[WORD_W-1:0];
            in_item_reg.write_data <= s_axis_tdata[WORD_W +: DATA_W];
            in_item_reg.pin_sample <= s_axis_tdata[WORD_W+DATA_W +: DATA_W];
        end
        if (advance)
        begin
            out_res_reg.read_data  <= rd;
            out_res_reg.pin_drive  <= latch_next;
            out_res_reg.pin_enable <= oe;
            out_res_reg.pull_mode  <= pull_next;
            out_res_reg.event_irq  <= |eds_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_TDATA_W-RES_W){1'b0}}, out_res_reg};

    // input side only blocks when both registers are full and the sink stalls
    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_advance_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("result register not loaded after advance");

    a_events_only_from_ticks: assert property (@(posedge clk) disable iff (!rst_n)
        (|(eds_reg & ~$past(eds_reg))) |-> $past(tick_fire))
        else $error("event status set outside a tick");

    a_irq_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
        $past(advance) |-> (out_res_reg.event_irq == (|eds_reg)))
        else $error("interrupt disagrees with event status");

    a_enable_within_pins: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_res_reg.pin_enable & ~PIN_MASK) == '0))
        else $error("output enable set beyond the pin count");

endmodule
